// ----- sv/pcvo_pkg.sv -----
package pcvo_pkg;

    // Grid geometry in cells.
    localparam int X_CELLS = 256;
    localparam int Y_CELLS = 256;
    localparam int Z_CELLS = 32;

    localparam longint unsigned PLANE_CELLS = longint'(X_CELLS) * longint'(Y_CELLS);
    localparam longint unsigned GRID_CELLS  = PLANE_CELLS * longint'(Z_CELLS);
    localparam int LIN_W = $clog2(GRID_CELLS);

    // Occupancy storage: 64-bit words.
    localparam int WORD_W     = 64;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int GRID_WORDS = 32768;
    localparam int GRID_AW    = $clog2(GRID_WORDS);
    localparam longint unsigned GRID_BITS = longint'(GRID_WORDS) * longint'(WORD_W);

    localparam int COORD_W = 16;
    localparam int CELL_W  = 21;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 3;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;

    // Register reset values.
    localparam logic [CFG_W-1:0] X_LOW_RST        = 16'sd0;
    localparam logic [CFG_W-1:0] X_HIGH_RST       = 16'sd6553;
    localparam logic [CFG_W-1:0] Y_LOW_RST        = -16'sd3277;
    localparam logic [CFG_W-1:0] Y_HIGH_RST       = 16'sd3277;
    localparam logic [CFG_W-1:0] Z_LOW_RST        = -16'sd640;
    localparam logic [CFG_W-1:0] Z_HIGH_RST       = 16'sd179;
    localparam logic [CFG_W-1:0] PLANE_SCALE_RST  = 16'd2560;
    localparam logic [CFG_W-1:0] HEIGHT_SCALE_RST = 16'd2560;

    typedef enum logic [CFG_AW-1:0] {
        CFG_X_LOW        = 3'd0,
        CFG_X_HIGH       = 3'd1,
        CFG_Y_LOW        = 3'd2,
        CFG_Y_HIGH       = 3'd3,
        CFG_Z_LOW        = 3'd4,
        CFG_Z_HIGH       = 3'd5,
        CFG_PLANE_SCALE  = 3'd6,
        CFG_HEIGHT_SCALE = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_MULT,
        ST_INDEX,
        ST_READ,
        ST_RESULT
    } state_t;

endpackage

// ----- sv/point_cloud_voxel_occupancy_core.sv -----
// Binary 3-D occupancy grid built from lidar points, held in one 32768 x 64-bit
// synchronous memory with one write and one read port; an insert reads, modifies
// and writes back its word. The s_tuser command selects the operation: clear the grid,
// insert a point or read one 64-bit grid word; every beat accepted gives exactly one
// result beat. One command is in flight at a time. An insert passes through bounds
// check, scale multiply, linear index, memory read, then write-back and result; a
// read passes through memory read and result, and an unused command code goes
// straight to result. A clear writes zeros through the memory one word per cycle.
// After reset the same clearing pass runs before the first beat is accepted;
// configuration writes are taken at any time. Results wait in an output register,
// so the next command is accepted while the previous result is unread.
module point_cloud_voxel_occupancy_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [pcvo_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [pcvo_pkg::CFG_W-1:0]          cfg_wdata,
    // Command stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x[15:0], point_y[31:16], point_z[47:32], word_address[62:48], zero[63]
    input  logic [pcvo_pkg::S_TDATA_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [pcvo_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // in_range[0], cell_index[21:1], grid_word[85:22], zero[87:86]
    output logic [pcvo_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CW  = pcvo_pkg::COORD_W;
    localparam int AW  = pcvo_pkg::GRID_AW;
    localparam int WW  = pcvo_pkg::WORD_W;
    localparam int LW  = pcvo_pkg::LIN_W;
    localparam int BW  = pcvo_pkg::BIT_W;
    localparam int CLW = pcvo_pkg::CELL_W;

    // Control registers.
    pcvo_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0]    sweep_reg, sweep_next;

    // Configuration registers.
    logic signed [CW-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic signed [CW-1:0] z_low_reg, z_high_reg;
    logic [CW-1:0]        plane_scale_reg, height_scale_reg;

    // Item and datapath registers.
    pcvo_pkg::cmd_t       cmd_reg, cmd_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [AW-1:0]        waddr_reg, waddr_next;
    logic [CW-1:0]        off_x_reg, off_x_next, off_y_reg, off_y_next;
    logic [CW-1:0]        off_z_reg, off_z_next;
    logic                 bnd_ok_reg, bnd_ok_next;
    logic [CW-1:0]        cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic                 ax_ok_reg, ax_ok_next;
    logic [LW-1:0]        lin_reg, lin_next;
    logic                 ok_reg, ok_next;
    logic [AW-1:0]        maddr_reg, maddr_next;

    // Output payload registers.
    logic                 out_in_range_reg, out_in_range_next;
    logic [CLW-1:0]       out_cell_reg, out_cell_next;
    logic [WW-1:0]        out_word_reg, out_word_next;

    // Memory.
    logic [WW-1:0]        grid_mem [pcvo_pkg::GRID_WORDS];
    logic [WW-1:0]        rd_data_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WW-1:0]        mem_wdata;

    logic                 accept;
    logic                 out_free;
    logic [2*CW-1:0]      prod_x, prod_y, prod_z;

    assign s_tready = (state_reg == pcvo_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_word_reg, out_cell_reg, out_in_range_reg};

    assign prod_x = off_x_reg * plane_scale_reg;
    assign prod_y = off_y_reg * plane_scale_reg;
    assign prod_z = off_z_reg * height_scale_reg;

    always_comb begin
        state_next        = state_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        sweep_next        = sweep_reg;
        cmd_next          = cmd_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        pz_next           = pz_reg;
        waddr_next        = waddr_reg;
        off_x_next        = off_x_reg;
        off_y_next        = off_y_reg;
        off_z_next        = off_z_reg;
        bnd_ok_next       = bnd_ok_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        ax_ok_next        = ax_ok_reg;
        lin_next          = lin_reg;
        ok_next           = ok_reg;
        maddr_next        = maddr_reg;
        out_in_range_next = out_in_range_reg;
        out_cell_next     = out_cell_reg;
        out_word_next     = out_word_reg;
        mem_we            = 1'b0;
        mem_waddr         = sweep_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = maddr_reg;

        case (state_reg)
            pcvo_pkg::ST_INIT, pcvo_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == {AW{1'b1}}) begin
                    state_next = (state_reg == pcvo_pkg::ST_INIT) ? pcvo_pkg::ST_IDLE
                                                                  : pcvo_pkg::ST_RESULT;
                end
            end
            pcvo_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next   = pcvo_pkg::cmd_t'(s_tuser[1:0]);
                    px_next    = s_tdata[15:0];
                    py_next    = s_tdata[31:16];
                    pz_next    = s_tdata[47:32];
                    waddr_next = s_tdata[62:48];
                    ok_next    = 1'b0;
                    case (pcvo_pkg::cmd_t'(s_tuser[1:0]))
                        pcvo_pkg::CMD_CLEAR:  state_next = pcvo_pkg::ST_CLEAR;
                        pcvo_pkg::CMD_INSERT: state_next = pcvo_pkg::ST_CHECK;
                        pcvo_pkg::CMD_READ:   state_next = pcvo_pkg::ST_READ;
                        default:              state_next = pcvo_pkg::ST_RESULT;
                    endcase
                end
            end
            pcvo_pkg::ST_CHECK: begin
                // Offsets wrap when out of bounds; they are only used when in bounds,
                // where they fit in 16 unsigned bits.
                off_x_next  = CW'(px_reg - x_low_reg);
                off_y_next  = CW'(py_reg - y_low_reg);
                off_z_next  = CW'(pz_reg - z_low_reg);
                bnd_ok_next = (px_reg > x_low_reg) && (px_reg < x_high_reg) &&
                              (py_reg > y_low_reg) && (py_reg < y_high_reg) &&
                              (pz_reg > z_low_reg) && (pz_reg < z_high_reg);
                state_next  = pcvo_pkg::ST_MULT;
            end
            pcvo_pkg::ST_MULT: begin
                cx_next    = prod_x[2*CW-1:CW];
                cy_next    = prod_y[2*CW-1:CW];
                cz_next    = prod_z[2*CW-1:CW];
                state_next = pcvo_pkg::ST_INDEX;
            end
            pcvo_pkg::ST_INDEX: begin
                ax_ok_next = bnd_ok_reg &&
                             ({1'b0, cx_reg} < (CW+1)'(pcvo_pkg::X_CELLS)) &&
                             ({1'b0, cy_reg} < (CW+1)'(pcvo_pkg::Y_CELLS)) &&
                             ({1'b0, cz_reg} < (CW+1)'(pcvo_pkg::Z_CELLS));
                lin_next   = LW'(cz_reg) * LW'(pcvo_pkg::PLANE_CELLS) +
                             LW'(cy_reg) * LW'(pcvo_pkg::X_CELLS) + LW'(cx_reg);
                state_next = pcvo_pkg::ST_READ;
            end
            pcvo_pkg::ST_READ: begin
                mem_re = 1'b1;
                if (cmd_reg == pcvo_pkg::CMD_INSERT) begin
                    mem_raddr = lin_reg[BW +: AW];
                    ok_next   = ax_ok_reg && (64'(lin_reg) < pcvo_pkg::GRID_BITS);
                end else begin
                    mem_raddr = waddr_reg;
                    ok_next   = 1'b0;
                end
                maddr_next = mem_raddr;
                state_next = pcvo_pkg::ST_RESULT;
            end
            pcvo_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next     = 1'b1;
                    out_in_range_next = ok_reg;
                    out_cell_next     = ok_reg ? CLW'(lin_reg) : '0;
                    out_word_next     = (cmd_reg == pcvo_pkg::CMD_READ) ? rd_data_reg : '0;
                    // The point's word was read in the previous state; set its bit.
                    mem_we            = ok_reg;
                    mem_waddr         = maddr_reg;
                    mem_wdata         = rd_data_reg | (WW'(1) << lin_reg[BW-1:0]);
                    state_next        = pcvo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcvo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcvo_pkg::ST_INIT;
            m_tvalid_reg <= 1'b0;
            sweep_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            sweep_reg    <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg        <= pcvo_pkg::X_LOW_RST;
            x_high_reg       <= pcvo_pkg::X_HIGH_RST;
            y_low_reg        <= pcvo_pkg::Y_LOW_RST;
            y_high_reg       <= pcvo_pkg::Y_HIGH_RST;
            z_low_reg        <= pcvo_pkg::Z_LOW_RST;
            z_high_reg       <= pcvo_pkg::Z_HIGH_RST;
            plane_scale_reg  <= pcvo_pkg::PLANE_SCALE_RST;
            height_scale_reg <= pcvo_pkg::HEIGHT_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (pcvo_pkg::cfg_reg_t'(cfg_index))
                pcvo_pkg::CFG_X_LOW:        x_low_reg        <= cfg_wdata;
                pcvo_pkg::CFG_X_HIGH:       x_high_reg       <= cfg_wdata;
                pcvo_pkg::CFG_Y_LOW:        y_low_reg        <= cfg_wdata;
                pcvo_pkg::CFG_Y_HIGH:       y_high_reg       <= cfg_wdata;
                pcvo_pkg::CFG_Z_LOW:        z_low_reg        <= cfg_wdata;
                pcvo_pkg::CFG_Z_HIGH:       z_high_reg       <= cfg_wdata;
                pcvo_pkg::CFG_PLANE_SCALE:  plane_scale_reg  <= cfg_wdata;
                pcvo_pkg::CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        pz_reg           <= pz_next;
        waddr_reg        <= waddr_next;
        off_x_reg        <= off_x_next;
        off_y_reg        <= off_y_next;
        off_z_reg        <= off_z_next;
        bnd_ok_reg       <= bnd_ok_next;
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        cz_reg           <= cz_next;
        ax_ok_reg        <= ax_ok_next;
        lin_reg          <= lin_next;
        ok_reg           <= ok_next;
        maddr_reg        <= maddr_next;
        out_in_range_reg <= out_in_range_next;
        out_cell_reg     <= out_cell_next;
        out_word_reg     <= out_word_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= grid_mem[mem_raddr];
        end
    end

endmodule
